FILE: rtl/sfc_pkg.sv
// Package: shared constants, codes and payload types of the curve index mapper.
`default_nettype none
package sfc_pkg;
    localparam int COORD_BITS = 10;
    localparam int IDX_BITS   = 30;
    localparam int GRID_BITS  = 11;
    localparam int NB_W       = $clog2(COORD_BITS + 1);
    localparam int POS_W      = $clog2(3 * COORD_BITS + 1);
    localparam int MUL_W      = 2 * GRID_BITS + COORD_BITS + 1;
    localparam int PIPE_LAST  = 2 * IDX_BITS;

    localparam logic [1:0] REG_CURVE_MODE = 2'd0;
    localparam logic [1:0] REG_GRID_X     = 2'd1;
    localparam logic [1:0] REG_GRID_Y     = 2'd2;
    localparam logic [1:0] REG_GRID_Z     = 2'd3;

    localparam logic MODE_ROW_MAJOR = 1'b0;
    localparam logic MODE_MORTON    = 1'b1;
    localparam logic REQ_ENCODE     = 1'b0;
    localparam logic REQ_DECODE     = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [COORD_BITS-1:0] in_x;
        logic [COORD_BITS-1:0] in_y;
        logic [COORD_BITS-1:0] in_z;
        logic [IDX_BITS-1:0]   in_index;
    } sfc_req_t;

    typedef struct packed {
        logic [IDX_BITS-1:0]   out_index;
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic [COORD_BITS-1:0] out_z;
        logic                  grid_not_pow2;
    } sfc_result_t;
endpackage
`default_nettype wire

FILE: rtl/space_filling_curve_index_map_core.sv
// Top level: pipelined row-major / Morton coordinate and index converter.
// Pipeline: the input register, then the stages of the two cascaded one-bit-per-stage
// dividers, then the registered result and the done strobe.
// Throughput: one request per cycle; busy is never raised.
// Reset clears the pipeline and the strobe and sets row-major mode with grid counts of 1.
// The receiver cannot stall, so the pipeline advances every cycle.
`default_nettype none
module space_filling_curve_index_map_core
    import sfc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire sfc_req_t             req,
    output logic                      done,
    output sfc_result_t               result,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [GRID_BITS-1:0] cfg_data
);
    typedef struct packed {
        logic                  valid;
        logic                  req_type;
        logic                  flag;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] cz;
        logic [MUL_W-1:0]      acc;
        logic [GRID_BITS-1:0]  rem;
        logic [IDX_BITS-1:0]   qd;
        logic [COORD_BITS-1:0] xq;
    } sfc_pipe_t;

    logic                 mode_reg;
    logic [GRID_BITS-1:0] grid_x_reg, grid_y_reg, grid_z_reg;
    logic [GRID_BITS-1:0] n [3];
    logic [NB_W-1:0]      nb [3];
    logic                 not_pow2;

    sfc_pipe_t p_reg  [0:PIPE_LAST];
    sfc_pipe_t p_next [1:PIPE_LAST];
    logic [IDX_BITS-1:0]   mort_idx;
    logic [COORD_BITS-1:0] mort_c [3];
    logic [COORD_BITS-1:0] cin [3];
    sfc_result_t result_reg, result_next;
    logic        done_reg;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ROW_MAJOR;
            grid_x_reg <= GRID_BITS'(1);
            grid_y_reg <= GRID_BITS'(1);
            grid_z_reg <= GRID_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CURVE_MODE: mode_reg   <= cfg_data[0];
                REG_GRID_X:     grid_x_reg <= cfg_data;
                REG_GRID_Y:     grid_y_reg <= cfg_data;
                REG_GRID_Z:     grid_z_reg <= cfg_data;
                default:        mode_reg   <= mode_reg;
            endcase
        end
    end

    // A count of zero behaves as a count of one; bit counts are capped at COORD_BITS.
    always_comb
    begin
        n[0] = (grid_x_reg == '0) ? GRID_BITS'(1) : grid_x_reg;
        n[1] = (grid_y_reg == '0) ? GRID_BITS'(1) : grid_y_reg;
        n[2] = (grid_z_reg == '0) ? GRID_BITS'(1) : grid_z_reg;
        not_pow2 = 1'b0;
        for (int d = 0; d < 3; d++)
        begin
            nb[d] = '0;
            for (int k = 1; k < GRID_BITS; k++)
                if (n[d][k])
                    nb[d] = (k > COORD_BITS) ? NB_W'(COORD_BITS) : NB_W'(k);
            if ((n[d] & (n[d] - GRID_BITS'(1))) != '0)
                not_pow2 = 1'b1;
        end
    end

    // Morton position of bit b of axis d: all lower levels of every axis, then the
    // earlier axes that still have a bit at this level.
    always_comb
    begin
        logic [POS_W-1:0] pos;
        cin[0] = p_reg[0].cx;
        cin[1] = p_reg[0].cy;
        cin[2] = p_reg[0].cz;
        mort_idx = '0;
        for (int d = 0; d < 3; d++)
            mort_c[d] = '0;
        for (int d = 0; d < 3; d++)
        begin
            for (int b = 0; b < COORD_BITS; b++)
            begin
                pos = '0;
                for (int e = 0; e < 3; e++)
                begin
                    pos = pos + ((NB_W'(b) < nb[e]) ? POS_W'(b) : POS_W'(nb[e]));
                    if (e < d && NB_W'(b) < nb[e])
                        pos = pos + POS_W'(1);
                end
                if (NB_W'(b) < nb[d] && pos < POS_W'(IDX_BITS))
                begin
                    if (cin[d][b])
                        mort_idx[pos] = 1'b1;
                    mort_c[d][b] = p_reg[0].qd[pos];
                end
            end
        end
    end

    always_comb
    begin
        logic [GRID_BITS:0]   rsh;
        logic [GRID_BITS-1:0] dv;
        logic [GRID_BITS-1:0] rin;
        logic                 ge;
        for (int s = 1; s <= PIPE_LAST; s++)
        begin
            p_next[s] = p_reg[s-1];
            // Restoring division, one quotient bit a stage: by grid_x, then by grid_y.
            dv  = (s <= IDX_BITS) ? n[0] : n[1];
            rin = p_reg[s-1].rem;
            if (s == IDX_BITS + 1)
            begin
                rin = '0;
                p_next[s].xq = p_reg[s-1].rem[COORD_BITS-1:0];
            end
            rsh = {rin, p_reg[s-1].qd[IDX_BITS-1]};
            ge  = rsh >= {1'b0, dv};
            p_next[s].rem = ge ? GRID_BITS'(rsh - {1'b0, dv}) : rsh[GRID_BITS-1:0];
            p_next[s].qd  = {p_reg[s-1].qd[IDX_BITS-2:0], ge};
            if (s == 1)
            begin
                p_next[s].flag = (mode_reg == MODE_MORTON) && not_pow2;
                if (mode_reg == MODE_MORTON)
                begin
                    p_next[s].acc = MUL_W'(mort_idx);
                    p_next[s].cx  = mort_c[0];
                    p_next[s].cy  = mort_c[1];
                    p_next[s].cz  = mort_c[2];
                end
                else
                    p_next[s].acc = MUL_W'(p_reg[0].cz * n[1]);
            end
            else if (s == 2 && mode_reg == MODE_ROW_MAJOR)
                p_next[s].acc = MUL_W'((p_reg[1].acc[COORD_BITS+GRID_BITS-1:0]
                                + (COORD_BITS+GRID_BITS+1)'(p_reg[1].cy)) * n[0]);
            else if (s == 3 && mode_reg == MODE_ROW_MAJOR)
                p_next[s].acc = p_reg[2].acc + MUL_W'(p_reg[2].cx);
        end
    end

    always_comb
    begin
        result_next = '0;
        result_next.grid_not_pow2 = p_reg[PIPE_LAST].flag;
        if (p_reg[PIPE_LAST].req_type == REQ_ENCODE)
            result_next.out_index = p_reg[PIPE_LAST].acc[IDX_BITS-1:0];
        else if (mode_reg == MODE_MORTON)
        begin
            result_next.out_x = p_reg[PIPE_LAST].cx;
            result_next.out_y = p_reg[PIPE_LAST].cy;
            result_next.out_z = p_reg[PIPE_LAST].cz;
        end
        else
        begin
            result_next.out_x = p_reg[PIPE_LAST].xq;
            result_next.out_y = p_reg[PIPE_LAST].rem[COORD_BITS-1:0];
            result_next.out_z = p_reg[PIPE_LAST].qd[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= PIPE_LAST; s++)
                p_reg[s] <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            p_reg[0].valid    <= start && !busy;
            p_reg[0].req_type <= req.req_type;
            p_reg[0].flag     <= 1'b0;
            p_reg[0].cx       <= req.in_x;
            p_reg[0].cy       <= req.in_y;
            p_reg[0].cz       <= req.in_z;
            p_reg[0].acc      <= '0;
            p_reg[0].rem      <= '0;
            p_reg[0].qd       <= req.in_index;
            p_reg[0].xq       <= '0;
            for (int s = 1; s <= PIPE_LAST; s++)
                p_reg[s] <= p_next[s];
            done_reg   <= p_reg[PIPE_LAST].valid;
            result_reg <= result_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_flag_mode: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.grid_not_pow2 |-> mode_reg == MODE_MORTON)
        else $error("power-of-two flag outside Morton mode");
    a_encode_no_coord: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(p_reg[PIPE_LAST].req_type) == REQ_ENCODE
        |-> result.out_x == '0 && result.out_y == '0 && result.out_z == '0)
        else $error("coordinates on an index result");
    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg[PIPE_LAST].valid |=> done)
        else $error("request lost at the output");
`endif
endmodule
`default_nettype wire
